>>> rtl/usd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Status codes and the lead byte and classification functions of the decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD      = 3'd1,
		ST_SURR     = 3'd2,
		ST_NONCHAR  = 3'd3,
		ST_OVERLONG = 3'd4,
		ST_INVALID  = 3'd5
	} dec_status_t;

	localparam logic [30:0] REPLACEMENT = 31'h0000FFFD;
	localparam logic [30:0] MAX_CODE    = 31'h0010FFFF;

	// sequence length announced by a lead byte, zero for an ASCII byte or a bad lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		if (b[7:5] == 3'b110) begin
			n = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			n = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			n = 3'd4;
		end else if (b[7:2] == 6'b111110) begin
			n = 3'd5;
		end else if (b[7:1] == 7'b1111110) begin
			n = 3'd6;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

	// payload bits carried by a lead byte of the given length
	function automatic logic [30:0] lead_payload(input logic [7:0] b, input logic [2:0] n);
		logic [30:0] v;
		case (n)
			3'd2:    v = {26'd0, b[4:0]};
			3'd3:    v = {27'd0, b[3:0]};
			3'd4:    v = {28'd0, b[2:0]};
			3'd5:    v = {29'd0, b[1:0]};
			default: v = {30'd0, b[0]};
		endcase
		return v;
	endfunction

	function automatic logic [2:0] bytes_needed(input logic [30:0] v);
		logic [2:0] n;
		if (v < 31'h00000080) begin
			n = 3'd1;
		end else if (v < 31'h00000800) begin
			n = 3'd2;
		end else if (v < 31'h00010000) begin
			n = 3'd3;
		end else if (v < 31'h00200000) begin
			n = 3'd4;
		end else if (v < 31'h04000000) begin
			n = 3'd5;
		end else begin
			n = 3'd6;
		end
		return n;
	endfunction

	function automatic dec_status_t classify(input logic [30:0] v, input logic [2:0] n);
		dec_status_t s;
		if (v > MAX_CODE) begin
			s = ST_BAD;
		end else if (v >= 31'h0000D800 && v <= 31'h0000DFFF) begin
			s = ST_SURR;
		end else if ((v >= 31'h0000FDD0 && v <= 31'h0000FDEF) || (&v[15:1])) begin
			s = ST_NONCHAR;
		end else if (bytes_needed(v) < n) begin
			s = ST_OVERLONG;
		end else begin
			s = ST_OK;
		end
		return s;
	endfunction

endpackage

>>> rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Input byte register, single pass decode, output result register.
// ----------------------------------------------------------------------------
// One byte per input beat on in_valid/in_stall/in_byte; one result per output
// beat on out_valid/out_stall with status, code_point and last.
// A byte is registered in the byte register on acceptance and decoded from
// there; its result, if any, is registered in the output register.
// Throughput is one byte per cycle unless a stall holds. A byte that breaks
// an open sequence and also yields a result of its own as a fresh lead is
// decoded twice: the invalid result first, then again from the byte register.
// Bytes that only start or extend a sequence give no result beat.
// The output register is the only result storage: while out_stall holds a
// waiting result, a byte that gives a result waits in the byte register and
// in_stall rises; bytes that give no result still pass.
// Reset clears the byte and result valid flags and the sequence state, so the
// decoder expects a lead byte.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [30:0] code_point,
	output logic        last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [2:0]  seq_len_q;
	logic [2:0]  seq_pos_q;
	logic [30:0] accum_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [30:0] code_q;
	logic        last_q;

	logic        out_free;
	logic        emit;
	logic        fire;
	logic        consume;
	logic [2:0]  len_d;
	logic [2:0]  pos_d;
	logic [30:0] accum_d;
	usd_pkg::dec_status_t st_d;
	logic [30:0] cp_d;
	logic        last_d;

	logic        is_ascii;
	logic [2:0]  ld_len;
	logic        lead_res;
	logic [30:0] cont_acc;
	logic [2:0]  cont_pos;

	assign out_free = !out_valid_q || !out_stall;
	assign is_ascii = !byte_s1[7];
	assign ld_len   = usd_pkg::lead_len(byte_s1);
	assign lead_res = is_ascii || (ld_len == 3'd0);
	assign cont_acc = {accum_q[24:0], byte_s1[5:0]};
	assign cont_pos = seq_pos_q + 3'd1;

	always_comb begin
		emit    = 1'b0;
		consume = 1'b0;
		len_d   = seq_len_q;
		pos_d   = seq_pos_q;
		accum_d = accum_q;
		st_d    = usd_pkg::ST_OK;
		cp_d    = {23'd0, byte_s1};
		last_d  = 1'b1;
		if (seq_len_q == 3'd0) begin
			if (is_ascii) begin
				emit = 1'b1;
			end else if (ld_len == 3'd0) begin
				emit    = 1'b1;
				st_d    = usd_pkg::ST_INVALID;
				cp_d    = usd_pkg::REPLACEMENT;
				accum_d = usd_pkg::REPLACEMENT;
			end else begin
				len_d   = ld_len;
				pos_d   = 3'd1;
				accum_d = usd_pkg::lead_payload(byte_s1, ld_len);
			end
			consume = 1'b1;
		end else if (byte_s1[7:6] != 2'b10) begin
			emit   = 1'b1;
			st_d   = usd_pkg::ST_INVALID;
			cp_d   = usd_pkg::REPLACEMENT;
			last_d = !lead_res;
			if (lead_res) begin
				// hold the byte and decode it again as a lead
				len_d   = 3'd0;
				pos_d   = 3'd0;
				accum_d = usd_pkg::REPLACEMENT;
			end else begin
				len_d   = ld_len;
				pos_d   = 3'd1;
				accum_d = usd_pkg::lead_payload(byte_s1, ld_len);
				consume = 1'b1;
			end
		end else begin
			accum_d = cont_acc;
			consume = 1'b1;
			if (cont_pos >= seq_len_q) begin
				emit  = 1'b1;
				st_d  = usd_pkg::classify(cont_acc, seq_len_q);
				cp_d  = cont_acc;
				len_d = 3'd0;
				pos_d = 3'd0;
			end else begin
				pos_d = cont_pos;
			end
		end
	end

	assign fire     = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !(fire && consume);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			seq_len_q   <= 3'd0;
			seq_pos_q   <= 3'd0;
			accum_q     <= 31'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (fire && consume) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				seq_len_q <= len_d;
				seq_pos_q <= pos_d;
				accum_q   <= accum_d;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
		if (fire && emit) begin
			status_q <= st_d;
			code_q   <= cp_d;
			last_q   <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign code_point = code_q;
	assign last       = last_q;

endmodule

>>> rtl/utf8_stream_decoder_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port level properties of the decoder, bound to every decoder instance.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [30:0] code_point,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(code_point)
			&& $stable(last))
		else $error("stalled result beat changed");

	a_invalid_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == usd_pkg::ST_INVALID |-> code_point == usd_pkg::REPLACEMENT)
		else $error("invalid sequence without replacement character");

	a_first_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == usd_pkg::ST_INVALID)
		else $error("non-final beat that is not an invalid sequence");

	a_bad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == usd_pkg::ST_BAD |-> code_point > usd_pkg::MAX_CODE)
		else $error("bad value within code space");

endmodule

bind utf8_stream_decoder utf8_stream_decoder_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.code_point (code_point),
	.last       (last)
);
